/* rtl/track_id_mixed_radix_decode_defines.svh */
// Assertion macros, clocked on aclk and disabled while aresetn is low.
`ifndef TRACK_ID_MIXED_RADIX_DECODE_DEFINES_SVH
`define TRACK_ID_MIXED_RADIX_DECODE_DEFINES_SVH

// Condition holds in the same cycle.
`define TIDMRD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Condition holds in the next cycle.
`define TIDMRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tidmrd_pkg.sv */
package tidmrd_pkg;

    localparam int FACET_W        = 10;
    localparam int RADIX_W        = FACET_W + 1;
    localparam int INDEX_W        = 11;
    localparam int ICOUNT_W       = 5;
    localparam int TRACK_W        = 64;
    localparam int NFULL_W        = 7;
    localparam int ID_WIDTH_DEF   = 64;
    localparam int MAX_DIGITS_DEF = 32;

    localparam logic [FACET_W-1:0] FACET_RESET = FACET_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_DIV_END,
        ST_RD,
        ST_LD,
        ST_WAIT
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic clr_rem;
        logic wr_en;
        logic rd_en;
        logic out_load;
        logic out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic out_valid;
        logic out_taken;
    } dp_sts_t;

endpackage

/* rtl/tidmrd_dp.sv */
module tidmrd_dp
    import tidmrd_pkg::*;
#(
    parameter int ID_WIDTH   = ID_WIDTH_DEF,
    parameter int MAX_DIGITS = MAX_DIGITS_DEF,
    parameter int ADDR_W     = $clog2(MAX_DIGITS)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [FACET_W-1:0]        cfg_wr_data,
    input  logic [ID_WIDTH-1:0]       track_code,
    input  dp_cmd_t                   cmd,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [ADDR_W-1:0]         rd_addr,
    output dp_sts_t                   sts,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [INDEX_W-1:0] m_facet_index,
    output logic                      m_last
);

    logic [FACET_W-1:0]  facet_count_reg;
    logic [RADIX_W-1:0]  radix;
    logic [ID_WIDTH-1:0] quot_reg;
    logic [FACET_W-1:0]  rem_reg;
    logic [RADIX_W-1:0]  trial;
    logic                fits;
    logic [FACET_W-1:0]  digit_mem [MAX_DIGITS];
    logic [FACET_W-1:0]  rd_data_reg;
    logic                out_valid_reg;
    logic [INDEX_W-1:0]  out_index_reg;
    logic                out_last_reg;

    assign radix = {1'b0, facet_count_reg} + RADIX_W'(1);
    assign trial = {rem_reg, quot_reg[ID_WIDTH-1]};
    assign fits  = (trial >= radix);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            facet_count_reg <= FACET_RESET;
        end else if (cfg_wr_en) begin
            facet_count_reg <= cfg_wr_data;
        end
    end

    // restoring divide, one quotient bit per step, quotient shifts in place
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            quot_reg <= track_code;
            rem_reg  <= '0;
        end else if (cmd.step) begin
            quot_reg <= {quot_reg[ID_WIDTH-2:0], fits};
            rem_reg  <= fits ? FACET_W'(trial - radix) : trial[FACET_W-1:0];
        end else if (cmd.clr_rem) begin
            rem_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            digit_mem[wr_addr] <= rem_reg;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= digit_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_index_reg <= {1'b0, rd_data_reg} - INDEX_W'(1);
            out_last_reg  <= cmd.out_last;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_facet_index = out_index_reg;
    assign m_last        = out_last_reg;

    assign sts.out_valid = out_valid_reg;
    assign sts.out_taken = out_valid_reg & m_ready;

endmodule

/* rtl/tidmrd_ctrl.sv */
`include "track_id_mixed_radix_decode_defines.svh"

module tidmrd_ctrl
    import tidmrd_pkg::*;
#(
    parameter int ID_WIDTH   = ID_WIDTH_DEF,
    parameter int MAX_DIGITS = MAX_DIGITS_DEF,
    parameter int ADDR_W     = $clog2(MAX_DIGITS)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [ICOUNT_W-1:0] interaction_count,
    output dp_cmd_t             cmd,
    output logic [ADDR_W-1:0]   wr_addr,
    output logic [ADDR_W-1:0]   rd_addr,
    input  dp_sts_t             sts
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int BIT_W = $clog2(ID_WIDTH);

    state_t            state_reg,   state_next;
    logic [BIT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [CNT_W-1:0]  div_idx_reg, div_idx_next;
    logic [CNT_W-1:0]  n_reg,       n_next;
    logic [CNT_W-1:0]  rd_idx_reg,  rd_idx_next;
    logic [NFULL_W-1:0] n_full;

    assign n_full = NFULL_W'(interaction_count) + NFULL_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            div_idx_reg <= '0;
            n_reg       <= '0;
            rd_idx_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            div_idx_reg <= div_idx_next;
            n_reg       <= n_next;
            rd_idx_reg  <= rd_idx_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        div_idx_next = div_idx_reg;
        n_next       = n_reg;
        rd_idx_next  = rd_idx_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        wr_addr      = ADDR_W'(div_idx_reg - CNT_W'(1));
        rd_addr      = rd_idx_reg[ADDR_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load     = 1'b1;
                    bit_cnt_next = '0;
                    div_idx_next = '0;
                    if (n_full > NFULL_W'(MAX_DIGITS)) begin
                        n_next = CNT_W'(MAX_DIGITS);
                    end else begin
                        n_next = CNT_W'(n_full);
                    end
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.step     = 1'b1;
                bit_cnt_next = bit_cnt_reg + BIT_W'(1);
                if (bit_cnt_reg == BIT_W'(ID_WIDTH - 1)) begin
                    state_next = ST_DIV_END;
                end
            end
            ST_DIV_END: begin
                // first division drops the trailing radix factor, store the rest
                cmd.wr_en   = (div_idx_reg != '0);
                cmd.clr_rem = 1'b1;
                if (div_idx_reg == n_reg) begin
                    rd_idx_next = n_reg - CNT_W'(1);
                    state_next  = ST_RD;
                end else begin
                    div_idx_next = div_idx_reg + CNT_W'(1);
                    bit_cnt_next = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_LD;
            end
            ST_LD: begin
                cmd.out_load = 1'b1;
                cmd.out_last = (rd_idx_reg == '0);
                state_next   = ST_WAIT;
            end
            ST_WAIT: begin
                if (sts.out_taken) begin
                    if (rd_idx_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        rd_idx_next = rd_idx_reg - CNT_W'(1);
                        state_next  = ST_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `TIDMRD_ASSERT_NEXT(a_load_sets_valid, cmd.out_load, sts.out_valid, "output word not raised")
    `TIDMRD_ASSERT_SAME(a_no_overwrite, cmd.out_load, !sts.out_valid, "pending word overwritten")
    `TIDMRD_ASSERT_SAME(a_wr_in_range, cmd.wr_en, (div_idx_reg != '0) && (div_idx_reg <= n_reg), "digit write out of range")
    `TIDMRD_ASSERT_NEXT(a_load_starts_div, cmd.load, (state_reg == ST_DIV) && (bit_cnt_reg == '0), "division not started")

endmodule

/* rtl/track_id_mixed_radix_decode.sv */
// Channel   Handshake            Word
// s_        s_valid / s_ready    s_track_code, s_interaction_count
// m_        m_valid / m_ready    m_facet_index, m_last
// cfg_      cfg_wr_en            cfg_wr_data (facet_count)
//
// n = min(s_interaction_count + 1, MAX_DIGITS) words per input word.
// The single bit-serial restoring divider runs n + 1 divisions per input word,
// one quotient bit a cycle; m_ready stalls hold the read-back of the digits.
// Digits go to a small RAM and are read back in reverse, one registered read per word.
// Reset: aresetn synchronous, active low; facet_count returns to 1.
// s_ready is high only between tracks; m_ready low holds the current word.
module track_id_mixed_radix_decode
    import tidmrd_pkg::*;
#(
    parameter int ID_WIDTH   = ID_WIDTH_DEF,
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [FACET_W-1:0]        cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [TRACK_W-1:0]        s_track_code,
    input  logic [ICOUNT_W-1:0]       s_interaction_count,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [INDEX_W-1:0] m_facet_index,
    output logic                      m_last
);

    localparam int ADDR_W = $clog2(MAX_DIGITS);

    dp_cmd_t           cmd;
    dp_sts_t           sts;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    tidmrd_ctrl #(
        .ID_WIDTH   (ID_WIDTH),
        .MAX_DIGITS (MAX_DIGITS),
        .ADDR_W     (ADDR_W)
    ) u_ctrl (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .interaction_count (s_interaction_count),
        .cmd               (cmd),
        .wr_addr           (wr_addr),
        .rd_addr           (rd_addr),
        .sts               (sts)
    );

    tidmrd_dp #(
        .ID_WIDTH   (ID_WIDTH),
        .MAX_DIGITS (MAX_DIGITS),
        .ADDR_W     (ADDR_W)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .track_code    (s_track_code[ID_WIDTH-1:0]),
        .cmd           (cmd),
        .wr_addr       (wr_addr),
        .rd_addr       (rd_addr),
        .sts           (sts),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_facet_index (m_facet_index),
        .m_last        (m_last)
    );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import tidmrd_pkg::*;

    typedef struct {
        logic signed [INDEX_W-1:0] facet_index;
        logic                      last;
    } facet_word_t;

    class track_digit_scoreboard;
        logic [FACET_W-1:0] facet_count = FACET_RESET;
        facet_word_t        expected_words[$];
        int                 errors = 0;

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        function void note_track(logic [TRACK_W-1:0] code, logic [ICOUNT_W-1:0] count);
            logic [TRACK_W-1:0] radix;
            logic [TRACK_W-1:0] q;
            logic [TRACK_W-1:0] d;
            logic [TRACK_W-1:0] digits[MAX_DIGITS_DEF];
            facet_word_t        w;
            int                 n;
            int                 i;
            radix = TRACK_W'(facet_count) + 1;
            q = code / radix;
            n = int'(count) + 1;
            if (n > MAX_DIGITS_DEF) begin
                n = MAX_DIGITS_DEF;
            end
            for (i = 0; i < n; i++) begin
                d = q % radix;
                q = (q - d) / radix;
                digits[i] = d;
            end
            for (i = 0; i < n; i++) begin
                w.facet_index = INDEX_W'(digits[n - 1 - i] - 1);
                w.last = (i == n - 1);
                expected_words.insert(expected_words.size(), w);
            end
        endfunction

        task check_word(logic signed [INDEX_W-1:0] facet_index, logic last);
            facet_word_t w;
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word facet_index=%0d last=%0b",
                                          facet_index, last));
            end else begin
                w = expected_words.pop_front();
                if (facet_index !== w.facet_index) begin
                    report_mismatch($sformatf("facet_index %0d, expected %0d",
                                              facet_index, w.facet_index));
                end
                if (last !== w.last) begin
                    report_mismatch($sformatf("last %0b, expected %0b", last, w.last));
                end
            end
        endtask

        function int pending_count();
            return expected_words.size();
        endfunction
    endclass

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      cfg_wr_en;
    logic [FACET_W-1:0]        cfg_wr_data;
    logic                      s_valid;
    logic                      s_ready;
    logic [TRACK_W-1:0]        s_track_code;
    logic [ICOUNT_W-1:0]       s_interaction_count;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [INDEX_W-1:0] m_facet_index;
    logic                      m_last;

    track_digit_scoreboard sb = new();
    int  send_idle = 0;
    int  recv_idle = 0;
    bit  hold_go = 1'b0;
    logic recv_hold;

    track_id_mixed_radix_decode uut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_track_code        (s_track_code),
        .s_interaction_count (s_interaction_count),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_facet_index       (m_facet_index),
        .m_last              (m_last)
    );

    always #5 aclk = ~aclk;

    initial begin
        #50_000_000;
        $display("Verification failed");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_word(m_facet_index, m_last);
        end
        m_ready <= !recv_hold && ($urandom_range(99) >= recv_idle);
    end

    initial begin
        wait (hold_go);
        @(posedge aclk);
        recv_hold <= 1'b1;
        repeat (4000) @(posedge aclk);
        recv_hold <= 1'b0;
    end

    task write_facet_count(logic [FACET_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.facet_count = value;
    endtask

    task send_track(logic [TRACK_W-1:0] code, logic [ICOUNT_W-1:0] count);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid             <= 1'b1;
        s_track_code        <= code;
        s_interaction_count <= count;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_track(code, count);
    endtask

    // drop valid, wait for every word, then let the divider settle
    task drain;
        s_valid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function logic [ICOUNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 70) begin
            return ICOUNT_W'($urandom_range(0, 7));
        end else if (r < 92) begin
            return ICOUNT_W'($urandom_range(8, 19));
        end
        return ICOUNT_W'($urandom_range(20, 31));
    endfunction

    function logic [TRACK_W-1:0] encode_track(int digits);
        logic [TRACK_W-1:0] radix;
        logic [TRACK_W-1:0] v;
        int                 k;
        radix = TRACK_W'(sb.facet_count) + 1;
        v = '0;
        for (k = 0; k < digits; k++) begin
            v = v * radix + ((sb.facet_count == 0) ? 0 : $urandom_range(1, sb.facet_count));
        end
        return v * radix;
    endfunction

    function logic [TRACK_W-1:0] pick_code(logic [ICOUNT_W-1:0] count);
        int                 r;
        logic [TRACK_W-1:0] v;
        r = $urandom_range(99);
        if (r < 55) begin
            return encode_track($urandom_range(1, int'(count) + 1));
        end else if (r < 75) begin
            return {$urandom, $urandom};
        end else if (r < 90) begin
            return TRACK_W'($urandom_range(0, 4095));
        end else if (r < 95) begin
            return '1;
        end
        v = {$urandom, $urandom};
        v[TRACK_W-1] = 1'b1;
        return v;
    endfunction

    initial begin
        int p;
        int i;
        logic [FACET_W-1:0]  facet;
        logic [ICOUNT_W-1:0] count;

        aresetn             <= 1'b0;
        cfg_wr_en           <= 1'b0;
        cfg_wr_data         <= '0;
        s_valid             <= 1'b0;
        s_track_code        <= '0;
        s_interaction_count <= '0;
        m_ready             <= 1'b0;
        recv_hold           <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_track('0, 0);
        send_track('1, 31);
        send_track('1, 0);
        send_track(64'h8000_0000_0000_0000, 31);
        send_track(64'd1, 5);
        send_track(64'h5555_5555_5555_5555, 20);
        drain();

        write_facet_count('0);
        send_track('1, 31);
        send_track({$urandom, $urandom}, 3);
        drain();

        write_facet_count(10'd1023);
        send_track('1, 31);
        send_track('0, 31);
        send_track(64'd1023, 2);
        send_track(encode_track(6), 5);
        send_track(64'hAAAA_AAAA_AAAA_AAAA, 10);
        send_track(64'd1024 * 64'd1024, 1);
        drain();

        write_facet_count(10'd1);
        send_track(encode_track(32), 31);
        send_track(64'd6, 31);
        drain();

        for (p = 0; p < 9; p++) begin
            facet = (p == 0) ? 10'd1023 : (p == 1) ? 10'd0 : (p == 2) ? 10'd1 :
                    (p == 4) ? 10'd2 : (p == 6) ? 10'd1023 :
                    FACET_W'($urandom_range(3, 1022));
            write_facet_count(facet);
            send_idle = (p < 3) ? 6 : (p < 6) ? 56 : 0;
            recv_idle = (p < 3) ? 56 : (p < 6) ? 6 : 0;
            if (p == 1) begin
                hold_go = 1'b1;
            end
            for (i = 0; i < 23; i++) begin
                count = pick_count();
                send_track(pick_code(count), count);
            end
            drain();
        end

        repeat (20) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
